FILE: src/dotid_pkg.sv
// Shared types and constants for the dot island detector.
package dotid_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_RADIUS_SQ    = 3'd2;
  localparam logic [2:0] REG_DETECT_EN    = 3'd3;
  localparam logic [2:0] REG_ISLAND_LIMIT = 3'd4;

  // Fixed field widths.
  localparam int DIM_W    = 13;
  localparam int RAD_W    = 26;
  localparam int LIMIT_W  = 6;
  localparam int SUM_W    = 36;
  localparam int JOIN_W   = 25;
  localparam int OUT_IDX_W = 5;
  localparam int OUT_CNT_W = 6;
  localparam int OUT_CRD_W = 12;
  localparam int DIV_STEP_W = 6;

  // Back end sequencer states.
  typedef enum logic [3:0] {
    B_IDLE,
    B_CHECK,
    B_RD,
    B_CMP,
    B_DIV,
    B_WR,
    B_OPEN,
    B_POST,
    B_EM_START,
    B_EM_RD,
    B_EM_LOAD,
    B_EM_EMPTY,
    B_FIN
  } back_state_t;

endpackage

FILE: src/dotid_front.sv
// Front end: raster counters and classification of incoming pixels.
module dotid_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  pixel,
  input  logic [dotid_pkg::DIM_W-1:0] frame_width,
  input  logic [dotid_pkg::DIM_W-1:0] frame_height,
  input  logic                        detect_enable,
  input  logic                        q_full,
  output logic                        q_push,
  output logic [2*COORD_BITS+1:0]     q_entry
);
  import dotid_pkg::*;

  localparam int DW = (COORD_BITS + 1 > DIM_W) ? COORD_BITS + 1 : DIM_W;
  localparam int DIM_MAX = 1 << COORD_BITS;

  logic [COORD_BITS-1:0] column;
  logic [COORD_BITS-1:0] row;
  logic [DW-1:0]         wc;
  logic [DW-1:0]         hc;
  logic                  row_end;
  logic                  frame_end;
  logic                  fg;
  logic                  accept;

  // Clamp the frame size into the coordinate range.
  always_comb begin
    if (frame_width == '0) wc = DW'(1);
    else if (DW'(frame_width) > DW'(DIM_MAX)) wc = DW'(DIM_MAX);
    else wc = DW'(frame_width);
    if (frame_height == '0) hc = DW'(1);
    else if (DW'(frame_height) > DW'(DIM_MAX)) hc = DW'(DIM_MAX);
    else hc = DW'(frame_height);
  end

  assign accept    = in_valid && !q_full;
  assign in_stall  = q_full;
  assign row_end   = (DW'(column) + DW'(1)) >= wc;
  assign frame_end = row_end && ((DW'(row) + DW'(1)) >= hc);
  assign fg        = (pixel != 8'd0) && detect_enable;

  // Only foreground pixels and frame ends need work in the back end.
  assign q_push  = accept && (fg || frame_end);
  assign q_entry = {frame_end, fg, row, column};

  // Raster position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else if (accept) begin
      if (row_end) begin
        column <= '0;
        row    <= frame_end ? '0 : row + 1'b1;
      end else begin
        column <= column + 1'b1;
      end
    end
  end

endmodule

FILE: src/dotid_queue.sv
// Two-entry queue between the front end and the back end.
module dotid_queue #(
  parameter int WIDTH = 26
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);
  import dotid_pkg::*;

  logic [WIDTH-1:0] slot [2];
  logic             rd_ptr;
  logic             wr_ptr;
  logic [1:0]       fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign head      = slot[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

endmodule

FILE: src/dotid_div.sv
// Two-lane restoring divider, one quotient bit per lane each cycle.
module dotid_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [dotid_pkg::SUM_W-1:0]  dividend_a,
  input  logic [dotid_pkg::SUM_W-1:0]  dividend_b,
  input  logic [dotid_pkg::JOIN_W-1:0] divisor,
  output logic                         done,
  output logic [dotid_pkg::SUM_W-1:0]  quot_a,
  output logic [dotid_pkg::SUM_W-1:0]  quot_b
);
  import dotid_pkg::*;

  logic [SUM_W-1:0]      dvd_a, dvd_b;
  logic [JOIN_W-1:0]     rem_a, rem_b;
  logic [JOIN_W-1:0]     dsr;
  logic [DIV_STEP_W-1:0] step;
  logic                  busy;
  logic [JOIN_W:0]       sh_a, sh_b;
  logic                  ge_a, ge_b;

  // One shift and trial subtract per lane.
  always_comb begin
    sh_a = {rem_a, dvd_a[SUM_W-1]};
    sh_b = {rem_b, dvd_b[SUM_W-1]};
    ge_a = sh_a >= {1'b0, dsr};
    ge_b = sh_b >= {1'b0, dsr};
  end

  assign quot_a = dvd_a;
  assign quot_b = dvd_b;

  // Data path; the quotient shifts into the dividend register.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_a <= dividend_a;
      dvd_b <= dividend_b;
      rem_a <= '0;
      rem_b <= '0;
      dsr   <= divisor;
    end else if (busy) begin
      rem_a <= ge_a ? JOIN_W'(sh_a - {1'b0, dsr}) : sh_a[JOIN_W-1:0];
      rem_b <= ge_b ? JOIN_W'(sh_b - {1'b0, dsr}) : sh_b[JOIN_W-1:0];
      dvd_a <= {dvd_a[SUM_W-2:0], ge_a};
      dvd_b <= {dvd_b[SUM_W-2:0], ge_b};
    end
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == DIV_STEP_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/dotid_back.sv
// Back end: island search, island store, centroid update and record output.
module dotid_back #(
  parameter int MAX_ISLANDS = 32,
  parameter int COORD_BITS  = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  logic [2*COORD_BITS+1:0]         q_head,
  output logic                            q_pop,
  input  logic [dotid_pkg::RAD_W-1:0]     radius_squared,
  input  logic [dotid_pkg::LIMIT_W-1:0]   island_limit,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dotid_pkg::OUT_IDX_W-1:0] island_index,
  output logic [dotid_pkg::OUT_CNT_W-1:0] island_count,
  output logic                            record_valid,
  output logic [dotid_pkg::OUT_CRD_W-1:0] center_x,
  output logic [dotid_pkg::OUT_CRD_W-1:0] center_y,
  output logic [dotid_pkg::OUT_CRD_W-1:0] left,
  output logic [dotid_pkg::OUT_CRD_W-1:0] top,
  output logic [dotid_pkg::OUT_CRD_W-1:0] right,
  output logic [dotid_pkg::OUT_CRD_W-1:0] bottom,
  output logic [dotid_pkg::JOIN_W-1:0]    pixel_total,
  output logic                            last_record
);
  import dotid_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int IDX_W = (MAX_ISLANDS > 1) ? $clog2(MAX_ISLANDS) : 1;
  localparam int CNT_W = $clog2(MAX_ISLANDS + 1);
  localparam int DSW   = (2 * C + 2 > RAD_W) ? 2 * C + 2 : RAD_W;

  typedef struct packed {
    logic [SUM_W-1:0]  sx;
    logic [SUM_W-1:0]  sy;
    logic [JOIN_W-1:0] cnt;
    logic [C-1:0]      cy;
    logic [C-1:0]      cx;
    logic [C-1:0]      bb;
    logic [C-1:0]      br;
    logic [C-1:0]      bt;
    logic [C-1:0]      bl;
  } rec_t;

  back_state_t state, state_next;

  rec_t              mem [MAX_ISLANDS];
  rec_t              rd_q;
  rec_t              work;
  rec_t              wr_rec;
  logic              mem_we;
  logic [IDX_W-1:0]  wr_addr;

  logic [C-1:0]      px, py;
  logic              pfg, pfe;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  islands_open;
  logic              frame_full;
  logic [6:0]        lim;
  logic              take;

  logic signed [C:0] dx, dy;
  logic [2*C+1:0]    sqx, sqy, dist_sq;
  logic              hit;
  logic              last_idx;
  logic              out_free;
  logic              load_rec, load_empty;
  logic              div_start, div_done;
  logic [JOIN_W-1:0] cnt_inc, divisor;
  logic [SUM_W-1:0]  sum_x_upd, sum_y_upd;
  logic [SUM_W-1:0]  quot_a, quot_b;

  // Effective island limit and the take decision.
  always_comb begin
    lim = ({1'b0, island_limit} > 7'(MAX_ISLANDS)) ? 7'(MAX_ISLANDS) : {1'b0, island_limit};
    take = pfg && !frame_full && (7'(islands_open) < lim);
  end

  // Squared distance from the pixel to the island read out of the store.
  always_comb begin
    dx      = $signed({1'b0, px}) - $signed({1'b0, rd_q.cx});
    dy      = $signed({1'b0, py}) - $signed({1'b0, rd_q.cy});
    sqx     = (2 * C + 2)'(dx * dx);
    sqy     = (2 * C + 2)'(dy * dy);
    dist_sq = sqx + sqy;
    hit     = DSW'(dist_sq) < DSW'(radius_squared);
  end

  // Updated sums and count of the island that takes the pixel; they feed the divider
  // directly so that it starts on the new values.
  assign last_idx  = (idx + 1'b1) == islands_open;
  assign out_free  = !out_valid || !out_stall;
  assign cnt_inc   = rd_q.cnt + 1'b1;
  assign sum_x_upd = rd_q.sx + SUM_W'(px);
  assign sum_y_upd = rd_q.sy + SUM_W'(py);
  assign divisor   = (cnt_inc == '0) ? JOIN_W'(1) : cnt_inc;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:     if (q_valid) state_next = B_CHECK;
      B_CHECK: begin
        if (take) state_next = (islands_open == '0) ? B_OPEN : B_RD;
        else state_next = pfe ? B_EM_START : B_IDLE;
      end
      B_RD:       state_next = B_CMP;
      B_CMP: begin
        if (hit) state_next = B_DIV;
        else state_next = last_idx ? B_OPEN : B_RD;
      end
      B_DIV:      if (div_done) state_next = B_WR;
      B_WR:       state_next = B_POST;
      B_OPEN:     state_next = B_POST;
      B_POST:     state_next = pfe ? B_EM_START : B_IDLE;
      B_EM_START: state_next = (islands_open == '0) ? B_EM_EMPTY : B_EM_RD;
      B_EM_RD:    state_next = B_EM_LOAD;
      B_EM_LOAD:  if (out_free) state_next = last_idx ? B_FIN : B_EM_RD;
      B_EM_EMPTY: if (out_free) state_next = B_FIN;
      B_FIN:      state_next = B_IDLE;
      default:    state_next = B_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    div_start  = 1'b0;
    load_rec   = 1'b0;
    load_empty = 1'b0;
    wr_addr    = idx[IDX_W-1:0];
    wr_rec     = work;
    unique case (state)
      B_IDLE:     q_pop = q_valid;
      B_CMP:      div_start = hit;
      B_WR: begin
        mem_we    = 1'b1;
        wr_rec.cx = quot_a[C-1:0];
        wr_rec.cy = quot_b[C-1:0];
      end
      B_OPEN: begin
        mem_we  = 1'b1;
        wr_addr = islands_open[IDX_W-1:0];
        wr_rec  = '{sx: SUM_W'(px), sy: SUM_W'(py), cnt: JOIN_W'(1), cy: py, cx: px,
                    bb: py, br: px, bt: py, bl: px};
      end
      B_EM_LOAD:  load_rec = out_free;
      B_EM_EMPTY: load_empty = out_free;
      default: ;
    endcase
  end

  // Island store with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_rec;
    rd_q <= mem[idx[IDX_W-1:0]];
  end

  // Working record and latched command.
  always_ff @(posedge clk) begin
    if (state == B_IDLE && q_valid) begin
      px  <= q_head[C-1:0];
      py  <= q_head[2*C-1:C];
      pfg <= q_head[2*C];
      pfe <= q_head[2*C+1];
    end
    if (state == B_CMP && hit) begin
      work.sx  <= sum_x_upd;
      work.sy  <= sum_y_upd;
      work.cnt <= cnt_inc;
      work.cx  <= rd_q.cx;
      work.cy  <= rd_q.cy;
      work.bl  <= (px < rd_q.bl) ? px : rd_q.bl;
      work.bt  <= (py < rd_q.bt) ? py : rd_q.bt;
      work.br  <= (px > rd_q.br) ? px : rd_q.br;
      work.bb  <= (py > rd_q.bb) ? py : rd_q.bb;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      idx          <= '0;
      islands_open <= '0;
      frame_full   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_CHECK || state == B_EM_START) idx <= '0;
      if (state == B_CMP && !hit && !last_idx) idx <= idx + 1'b1;
      if (load_rec && !last_idx) idx <= idx + 1'b1;
      if (state == B_OPEN) begin
        islands_open <= islands_open + 1'b1;
        if (7'(islands_open) + 7'd1 >= lim) frame_full <= 1'b1;
      end
      if (state == B_FIN) begin
        islands_open <= '0;
        frame_full   <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_rec || load_empty) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rec) begin
      island_index <= OUT_IDX_W'(idx);
      island_count <= OUT_CNT_W'(islands_open);
      record_valid <= 1'b1;
      center_x     <= OUT_CRD_W'(rd_q.cx);
      center_y     <= OUT_CRD_W'(rd_q.cy);
      left         <= OUT_CRD_W'(rd_q.bl);
      top          <= OUT_CRD_W'(rd_q.bt);
      right        <= OUT_CRD_W'(rd_q.br);
      bottom       <= OUT_CRD_W'(rd_q.bb);
      pixel_total  <= rd_q.cnt;
      last_record  <= last_idx;
    end else if (load_empty) begin
      island_index <= '0;
      island_count <= '0;
      record_valid <= 1'b0;
      center_x     <= '0;
      center_y     <= '0;
      left         <= '0;
      top          <= '0;
      right        <= '0;
      bottom       <= '0;
      pixel_total  <= '0;
      last_record  <= 1'b1;
    end
  end

  dotid_div u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (div_start),
    .dividend_a (sum_x_upd),
    .dividend_b (sum_y_upd),
    .divisor    (divisor),
    .done       (div_done),
    .quot_a     (quot_a),
    .quot_b     (quot_b)
  );

`ifndef SYNTHESIS
  a_open_bound: assert property (@(posedge clk) disable iff (rst)
    islands_open <= CNT_W'(MAX_ISLANDS))
    else $error("more islands open than the store holds");

  a_full_nonempty: assert property (@(posedge clk) disable iff (rst)
    frame_full |-> islands_open != '0)
    else $error("frame marked full with no island open");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    (load_rec || load_empty) |=> out_valid)
    else $error("loaded record not presented");

  a_no_write_in_emit: assert property (@(posedge clk) disable iff (rst)
    (state == B_EM_LOAD || state == B_EM_RD) |-> !mem_we)
    else $error("island store written during record output");
`endif

endmodule

FILE: src/dot_island_detector_core.sv
// Top level of the dot island detector: configuration registers and wiring.
//
//  channel | direction | handshake           | payload
//  in      | in        | in_valid / in_stall | pixel
//  out     | out       | out_valid/out_stall | island_index .. last_record
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A background pixel that does not end the frame is counted in the front end and never queued.
// A foreground pixel is compared in the back end against the open islands in turn until one
// is hit, and waits on the two-lane divider when it joins an island.
// At frame end the records are read out one at a time; the island store is one read port.
// Reset is synchronous and clears counters, queue and sequencer; the store is not cleared.
// A two-entry queue lets the front end keep taking pixels while the back end works.
module dot_island_detector_core #(
  parameter int MAX_ISLANDS = 32,
  parameter int COORD_BITS  = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      pixel,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dotid_pkg::OUT_IDX_W-1:0] island_index,
  output logic [dotid_pkg::OUT_CNT_W-1:0] island_count,
  output logic                            record_valid,
  output logic [dotid_pkg::OUT_CRD_W-1:0] center_x,
  output logic [dotid_pkg::OUT_CRD_W-1:0] center_y,
  output logic [dotid_pkg::OUT_CRD_W-1:0] left,
  output logic [dotid_pkg::OUT_CRD_W-1:0] top,
  output logic [dotid_pkg::OUT_CRD_W-1:0] right,
  output logic [dotid_pkg::OUT_CRD_W-1:0] bottom,
  output logic [dotid_pkg::JOIN_W-1:0]    pixel_total,
  output logic                            last_record,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [2:0]                      cfg_index,
  input  logic [dotid_pkg::RAD_W-1:0]     cfg_data
);
  import dotid_pkg::*;

  localparam int QW = 2 * COORD_BITS + 2;

  logic [DIM_W-1:0]   frame_width;
  logic [DIM_W-1:0]   frame_height;
  logic [RAD_W-1:0]   radius_squared;
  logic               detect_enable;
  logic [LIMIT_W-1:0] island_limit;

  logic          q_push, q_full, q_pop, q_valid;
  logic [QW-1:0] q_entry, q_head;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= DIM_W'(640);
      frame_height   <= DIM_W'(480);
      radius_squared <= RAD_W'(100);
      detect_enable  <= 1'b1;
      island_limit   <= LIMIT_W'(32);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width    <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height   <= cfg_data[DIM_W-1:0];
        REG_RADIUS_SQ:    radius_squared <= cfg_data;
        REG_DETECT_EN:    detect_enable  <= cfg_data[0];
        REG_ISLAND_LIMIT: island_limit   <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  dotid_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .pixel         (pixel),
    .frame_width   (frame_width),
    .frame_height  (frame_height),
    .detect_enable (detect_enable),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  dotid_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  dotid_back #(.MAX_ISLANDS(MAX_ISLANDS), .COORD_BITS(COORD_BITS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .radius_squared (radius_squared),
    .island_limit   (island_limit),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .island_index   (island_index),
    .island_count   (island_count),
    .record_valid   (record_valid),
    .center_x       (center_x),
    .center_y       (center_y),
    .left           (left),
    .top            (top),
    .right          (right),
    .bottom         (bottom),
    .pixel_total    (pixel_total),
    .last_record    (last_record)
  );

endmodule
